[rtl/hs_pkg.sv]
// hs_pkg: item types and fixed widths shared by the heap sorter modules
// depends on nothing; used by heap_sorter, hs_pick and hs_checker
`timescale 1ns / 1ps
`default_nettype none

package hs_pkg;

  localparam int WORD_W = 32;

  // one incoming list element
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     is_last;
  } in_item_t;

  // one sorted result
  typedef struct packed {
    logic signed [WORD_W-1:0] sorted_value;
    logic                     is_final;
    logic                     overflow;
  } out_item_t;

  // sift-down decision for one heap level
  typedef struct packed {
    logic move;   // a child beats the held value
    logic right;  // the winning child is the right one
  } pick_t;

endpackage

`default_nettype wire

[rtl/hs_pick.sv]
// hs_pick: one level of the sift-down comparison (held value against both children)
// depends on hs_pkg
`timescale 1ns / 1ps
`default_nettype none

module hs_pick (
  input  wire logic signed [hs_pkg::WORD_W-1:0] hold,
  input  wire logic signed [hs_pkg::WORD_W-1:0] left_value,
  input  wire logic signed [hs_pkg::WORD_W-1:0] right_value,
  input  wire logic                             right_ok,
  output hs_pkg::pick_t                         pick
);

  logic left_big;

  always_comb begin
    left_big = (left_value > hold);
    // ties keep the earlier candidate
    if (left_big) begin
      pick.right = right_ok && (right_value > left_value);
    end else begin
      pick.right = right_ok && (right_value > hold);
    end
    pick.move = left_big || pick.right;
  end

endmodule

`default_nettype wire

[rtl/heap_sorter.sv]
// heap_sorter: collects a list, heap-sorts it in place in one store, emits it ascending
// depends on hs_pkg and hs_pick
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  payload             handshake
// item      in         hs_pkg::in_item_t   item_valid / item_stall
// result    out        hs_pkg::out_item_t  result_valid / result_stall
//
// loading takes one item per cycle; the store is written as each item arrives, up to MAX_ITEMS
// the sort is bound by the single read port: a sift-down level reads the left child, then
// the right child, then compares and writes back; each build step and each extraction also
// reads its operands through that port before the sift
// results leave one at a time, each read from the store before it is loaded; a result stall
// holds the output register and the emission, so items stay stalled until the final result
// is loaded; reset clears the sequencer, count and flags, the store itself is never cleared

module heap_sorter #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire hs_pkg::in_item_t  item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output hs_pkg::out_item_t      result
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  // sequencer codes
  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_BRD  = 4'd2;   // build: read the next parent
  localparam logic [3:0] S_BH   = 4'd3;   // build: latch it as the held value
  localparam logic [3:0] S_SL   = 4'd4;   // sift: read left child or finish
  localparam logic [3:0] S_SR   = 4'd5;   // sift: read right child
  localparam logic [3:0] S_SC   = 4'd6;   // sift: compare and write back
  localparam logic [3:0] S_SEND = 4'd7;
  localparam logic [3:0] S_XA   = 4'd8;   // extract: read root
  localparam logic [3:0] S_XB   = 4'd9;   // extract: read heap end
  localparam logic [3:0] S_XC   = 4'd10;  // extract: root to end, start sift
  localparam logic [3:0] S_ERD  = 4'd11;
  localparam logic [3:0] S_EOUT = 4'd12;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic          overflow_seen;
  logic          extract;
  logic [AW-1:0] node;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] parent;
  logic [AW-1:0] emit_idx;

  logic signed [hs_pkg::WORD_W-1:0] hold;
  logic signed [hs_pkg::WORD_W-1:0] left_value;
  logic signed [hs_pkg::WORD_W-1:0] rdata;

  // heap store, one write and one read port, registered read
  logic [hs_pkg::WORD_W-1:0] heap_store [MAX_ITEMS];
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [hs_pkg::WORD_W-1:0] wdata;
  logic [AW-1:0]             raddr;

  // child indices of the current node
  logic [AW:0]   left_idx;
  logic [AW+1:0] right_idx;
  logic          no_child;
  logic          right_ok;
  hs_pkg::pick_t pick;

  logic          item_take;
  logic          emit_final;
  logic          emit_load;

  always_ff @(posedge clk) begin
    if (we) begin
      heap_store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= heap_store[raddr];
  end

  assign left_idx   = {node, 1'b1};
  assign right_idx  = {1'b0, left_idx} + (AW+2)'(1);
  assign no_child   = left_idx > {1'b0, last_idx};
  assign right_ok   = right_idx <= {2'b00, last_idx};

  assign item_stall = (state != S_LOAD);
  assign item_take  = item_valid && !item_stall;
  assign emit_final = (CW'(emit_idx) + CW'(1)) == count;
  assign emit_load  = (state == S_EOUT) && (!result_valid || !result_stall);

  hs_pick u_pick (
    .hold        (hold),
    .left_value  (left_value),
    .right_value (rdata),
    .right_ok    (right_ok),
    .pick        (pick)
  );

  // store port steering
  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = hold;
    raddr = emit_idx;
    case (state)
      S_LOAD: begin
        we    = item_take && (count < CW'(MAX_ITEMS));
        waddr = count[AW-1:0];
        wdata = item.value;
      end
      S_BRD: begin
        raddr = parent;
      end
      S_SL: begin
        // leaf reached: drop the held value here
        we    = no_child;
        raddr = left_idx[AW-1:0];
      end
      S_SR: begin
        raddr = right_idx[AW-1:0];
      end
      S_SC: begin
        we = 1'b1;
        if (pick.move) begin
          wdata = pick.right ? rdata : left_value;
        end
      end
      S_XA: begin
        raddr = '0;
      end
      S_XB: begin
        raddr = last_idx;
      end
      S_XC: begin
        // old root goes to the end of the shrinking heap
        we    = 1'b1;
        waddr = last_idx;
        wdata = left_value;
      end
      default: begin
        raddr = emit_idx;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
      extract       <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (item_take) begin
            if (count < CW'(MAX_ITEMS)) begin
              count <= count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (item.is_last) begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          extract  <= 1'b0;
          emit_idx <= '0;
          if (count < CW'(2)) begin
            state <= S_ERD;
          end else begin
            last_idx <= AW'(count - CW'(1));
            parent   <= AW'((count - CW'(2)) >> 1);
            state    <= S_BRD;
          end
        end
        S_BRD: begin
          node  <= parent;
          state <= S_BH;
        end
        S_BH: begin
          hold  <= rdata;
          state <= S_SL;
        end
        S_SL: begin
          state <= no_child ? S_SEND : S_SR;
        end
        S_SR: begin
          left_value <= rdata;
          state      <= S_SC;
        end
        S_SC: begin
          if (pick.move) begin
            node  <= pick.right ? right_idx[AW-1:0] : left_idx[AW-1:0];
            state <= S_SL;
          end else begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (!extract) begin
            if (parent == '0) begin
              extract <= 1'b1;
              state   <= S_XA;
            end else begin
              parent <= parent - AW'(1);
              state  <= S_BRD;
            end
          end else if (last_idx == '0) begin
            emit_idx <= '0;
            state    <= S_ERD;
          end else begin
            state <= S_XA;
          end
        end
        S_XA: begin
          state <= S_XB;
        end
        S_XB: begin
          left_value <= rdata;
          state      <= S_XC;
        end
        S_XC: begin
          hold     <= rdata;
          last_idx <= last_idx - AW'(1);
          node     <= '0;
          state    <= S_SL;
        end
        S_ERD: begin
          state <= S_EOUT;
        end
        S_EOUT: begin
          if (emit_load) begin
            if (emit_final) begin
              count         <= '0;
              overflow_seen <= 1'b0;
              state         <= S_LOAD;
            end else begin
              emit_idx <= emit_idx + AW'(1);
              state    <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // output register, drains independently of the next list's loading
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (emit_load) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      result.sorted_value <= rdata;
      result.is_final     <= emit_final;
      result.overflow     <= overflow_seen;
    end
  end

endmodule

`default_nettype wire

[rtl/hs_checker.sv]
// hs_checker: port-level checks on heap_sorter, bound into every heap_sorter instance
// depends on hs_pkg and heap_sorter
`timescale 1ns / 1ps
`default_nettype none

module hs_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_stall,
  input wire hs_pkg::in_item_t  item,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire hs_pkg::out_item_t result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // after reset nothing is pending and items are taken
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("unclean state after reset");

  // the last item of a list starts the sort, so no item is taken next
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.is_last |=> item_stall)
    else $error("item taken right after the last item");

  // a list is emitted whole before the next one loads
  a_emit_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_final |-> item_stall)
    else $error("item taken while a list is still being emitted");

endmodule

bind heap_sorter hs_checker u_hs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
